@@ sv/rau_pkg.sv @@
package rau_pkg;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_MUL = 2'd1;
  localparam logic [1:0] MODE_CMP = 2'd2;
  localparam logic [1:0] MODE_RSV = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] x_num;
    logic signed [31:0] x_den;
    logic signed [31:0] y_num;
    logic signed [31:0] y_den;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MULN, S_MULD, S_NEGY, S_GSET, S_GREM, S_GFIN,
    S_DMX, S_DMY, S_MXN, S_MYN, S_ADDN, S_MXD, S_DRN, S_DRD, S_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_NEG, OP_ADD, OP_MUL, OP_DIV, OP_GSET, OP_GREM, OP_GFIN
  } dp_op_t;

  typedef enum logic [3:0] {
    R_XN, R_XD, R_YN, R_YD, R_G, R_MX, R_MY, R_SN, R_SD, R_T, R_RN, R_RD
  } reg_sel_t;

  typedef struct packed {
    logic     load;
    logic     go;
    dp_op_t   op;
    reg_sel_t a_sel;
    reg_sel_t b_sel;
    reg_sel_t dst_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic keq;
    logic ka_zero;
    logic g_zero;
    logic mode_mul;
    logic mode_cmp;
  } dp_stat_t;

endpackage

@@ sv/rau_dp.sv @@
module rau_dp #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::in_word_t  in_data,
  input  rau_pkg::dp_cmd_t   cmd,
  output rau_pkg::dp_stat_t  stat,
  output rau_pkg::out_word_t out_data
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;
  localparam logic [W-1:0] WSIGN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] xn_r, xd_r, yn_r, yd_r, g_r, mx_r, my_r, sn_r, sd_r, t_r, rn_r, rd_r;
  logic [1:0]   mode_r;
  logic         ovf_r, zero_r;
  logic [W-1:0] ka_r, kb_r, gb_r;
  logic [2*W:0] p_r;
  logic [W-1:0] dv_r;
  logic [CW-1:0] cnt_r;
  logic         act_r, fin_r, done_r, eneg_r;
  rau_pkg::dp_op_t   eop_r;
  rau_pkg::reg_sel_t edst_r;
  rau_pkg::out_word_t out_r;

  logic [W-1:0] a_val, b_val, ma, mb;

  // Operand selection.
  always_comb begin
    case (cmd.a_sel)
      rau_pkg::R_XN: a_val = xn_r;
      rau_pkg::R_XD: a_val = xd_r;
      rau_pkg::R_YN: a_val = yn_r;
      rau_pkg::R_YD: a_val = yd_r;
      rau_pkg::R_G:  a_val = g_r;
      rau_pkg::R_MX: a_val = mx_r;
      rau_pkg::R_MY: a_val = my_r;
      rau_pkg::R_SN: a_val = sn_r;
      rau_pkg::R_SD: a_val = sd_r;
      rau_pkg::R_T:  a_val = t_r;
      rau_pkg::R_RN: a_val = rn_r;
      rau_pkg::R_RD: a_val = rd_r;
      default:       a_val = '0;
    endcase
    case (cmd.b_sel)
      rau_pkg::R_XN: b_val = xn_r;
      rau_pkg::R_XD: b_val = xd_r;
      rau_pkg::R_YN: b_val = yn_r;
      rau_pkg::R_YD: b_val = yd_r;
      rau_pkg::R_G:  b_val = g_r;
      rau_pkg::R_MX: b_val = mx_r;
      rau_pkg::R_MY: b_val = my_r;
      rau_pkg::R_SN: b_val = sn_r;
      rau_pkg::R_SD: b_val = sd_r;
      rau_pkg::R_T:  b_val = t_r;
      rau_pkg::R_RN: b_val = rn_r;
      rau_pkg::R_RD: b_val = rd_r;
      default:       b_val = '0;
    endcase
  end

  assign ma = a_val[W-1] ? (W'(0) - a_val) : a_val;
  assign mb = b_val[W-1] ? (W'(0) - b_val) : b_val;

  // Combinational operations.
  logic [W-1:0] neg_res, add_res, gfin_res;
  logic         neg_ovf, add_ovf;

  assign neg_res  = W'(0) - a_val;
  assign neg_ovf  = (a_val == WSIGN);
  assign add_res  = a_val + b_val;
  assign add_ovf  = (a_val[W-1] == b_val[W-1]) && (add_res[W-1] != a_val[W-1]);
  assign gfin_res = (ka_r == kb_r) ? gb_r :
                    ((!gb_r[W-1] && (gb_r != '0)) ? kb_r : (W'(0) - kb_r));

  // One step of the shared shift-add multiplier and restoring divider.
  logic [W:0]   mul_sum, div_tmp;
  logic [2*W:0] p_step;

  assign mul_sum = p_r[2*W:W] + (p_r[0] ? {1'b0, dv_r} : '0);
  assign div_tmp = p_r[2*W-1:W-1] - {1'b0, dv_r};

  always_comb begin
    if (eop_r == rau_pkg::OP_MUL) begin
      p_step = {1'b0, mul_sum, p_r[W-1:1]};
    end else if (div_tmp[W]) begin
      p_step = {1'b0, p_r[2*W-2:0], 1'b0};
    end else begin
      p_step = {1'b0, div_tmp[W-1:0], p_r[W-2:0], 1'b1};
    end
  end

  // Final value and overflow of a finished multiply or divide.
  logic [2*W-1:0] prod, lim;
  logic [W-1:0]   quo, eng_res;
  logic           eng_ovf;

  assign prod = p_r[2*W-1:0];
  assign lim  = eneg_r ? {{W{1'b0}}, WSIGN} : {{W{1'b0}}, WSIGN - W'(1)};
  assign quo  = p_r[W-1:0];

  always_comb begin
    if (eop_r == rau_pkg::OP_MUL) begin
      eng_res = eneg_r ? (W'(0) - prod[W-1:0]) : prod[W-1:0];
      eng_ovf = (prod > lim);
    end else begin
      eng_res = eneg_r ? (W'(0) - quo) : quo;
      eng_ovf = !eneg_r && quo[W-1];
    end
  end

  // Register write port.
  logic              wr_en;
  rau_pkg::reg_sel_t wr_sel;
  logic [W-1:0]      wr_val;

  always_comb begin
    wr_en  = 1'b0;
    wr_sel = cmd.dst_sel;
    wr_val = '0;
    if (fin_r && (eop_r != rau_pkg::OP_GREM)) begin
      wr_en  = 1'b1;
      wr_sel = edst_r;
      wr_val = eng_res;
    end else if (cmd.go) begin
      case (cmd.op)
        rau_pkg::OP_NEG: begin
          wr_en  = 1'b1;
          wr_val = neg_res;
        end
        rau_pkg::OP_ADD: begin
          wr_en  = 1'b1;
          wr_val = add_res;
        end
        rau_pkg::OP_GFIN: begin
          wr_en  = 1'b1;
          wr_val = gfin_res;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xn_r <= W'(in_data.x_num);
      xd_r <= W'(in_data.x_den);
      yn_r <= W'(in_data.y_num);
      yd_r <= W'(in_data.y_den);
    end else if (wr_en) begin
      case (wr_sel)
        rau_pkg::R_XN: xn_r <= wr_val;
        rau_pkg::R_XD: xd_r <= wr_val;
        rau_pkg::R_YN: yn_r <= wr_val;
        rau_pkg::R_YD: yd_r <= wr_val;
        rau_pkg::R_G:  g_r  <= wr_val;
        rau_pkg::R_MX: mx_r <= wr_val;
        rau_pkg::R_MY: my_r <= wr_val;
        rau_pkg::R_SN: sn_r <= wr_val;
        rau_pkg::R_SD: sd_r <= wr_val;
        rau_pkg::R_T:  t_r  <= wr_val;
        rau_pkg::R_RN: rn_r <= wr_val;
        rau_pkg::R_RD: rd_r <= wr_val;
        default: ;
      endcase
    end
  end

  // Mode and status flags of the word in flight.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      ovf_r  <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      if (fin_r && (eop_r != rau_pkg::OP_GREM) && eng_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.go && (((cmd.op == rau_pkg::OP_NEG) && neg_ovf) ||
                     ((cmd.op == rau_pkg::OP_ADD) && add_ovf))) begin
        ovf_r <= 1'b1;
      end
      if (cmd.go && (cmd.op == rau_pkg::OP_GFIN) && (gfin_res == '0)) begin
        zero_r <= 1'b1;
      end
    end
  end

  // Euclid state: sorted magnitudes and the sign source.
  always_ff @(posedge clk) begin
    if (cmd.go && (cmd.op == rau_pkg::OP_GSET)) begin
      gb_r <= b_val;
      if (ma <= mb) begin
        ka_r <= ma;
        kb_r <= mb;
      end else begin
        ka_r <= mb;
        kb_r <= ma;
      end
    end else if (fin_r && (eop_r == rau_pkg::OP_GREM)) begin
      ka_r <= p_r[2*W-1:W];
      kb_r <= ka_r;
    end
  end

  // Iterative engine: one bit per cycle, then the result is written back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      fin_r  <= 1'b0;
      done_r <= fin_r;
      if (cmd.go) begin
        case (cmd.op)
          rau_pkg::OP_MUL, rau_pkg::OP_DIV, rau_pkg::OP_GREM: act_r <= 1'b1;
          default: done_r <= 1'b1;
        endcase
      end else if (act_r && (cnt_r == CW'(W - 1))) begin
        act_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      eop_r  <= cmd.op;
      edst_r <= cmd.dst_sel;
      eneg_r <= a_val[W-1] ^ b_val[W-1];
      cnt_r  <= '0;
      case (cmd.op)
        rau_pkg::OP_MUL: begin
          p_r  <= {{(W+1){1'b0}}, mb};
          dv_r <= ma;
        end
        rau_pkg::OP_DIV: begin
          p_r  <= {{(W+1){1'b0}}, ma};
          dv_r <= mb;
        end
        default: begin
          p_r  <= {{(W+1){1'b0}}, kb_r};
          dv_r <= ka_r;
        end
      endcase
    end else if (act_r) begin
      p_r   <= p_step;
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (zero_r) begin
        out_r.res_num <= '0;
        out_r.res_den <= '0;
        out_r.status  <= rau_pkg::ST_ZERO;
      end else begin
        out_r.res_num <= 32'($signed(rn_r));
        out_r.res_den <= 32'($signed(rd_r));
        out_r.status  <= ovf_r ? rau_pkg::ST_OVF : rau_pkg::ST_OK;
      end
    end
  end

  assign out_data      = out_r;
  assign stat.done     = done_r;
  assign stat.keq      = (ka_r == kb_r);
  assign stat.ka_zero  = (ka_r == '0);
  assign stat.g_zero   = (g_r == '0);
  assign stat.mode_mul = (mode_r == rau_pkg::MODE_MUL);
  assign stat.mode_cmp = mode_r[1];

endmodule

@@ sv/rau_ctrl.sv @@
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rau_pkg::dp_stat_t stat,
  output rau_pkg::dp_cmd_t  cmd
);

  rau_pkg::ctl_state_t state_r, state_nxt;
  logic red_r, red_nxt;
  logic issued_r, issued_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt  = state_r;
    red_nxt    = red_r;
    issued_nxt = issued_r;
    if ((state_r != rau_pkg::S_IDLE) && (state_r != rau_pkg::S_DISP) &&
        (state_r != rau_pkg::S_OUT)) begin
      issued_nxt = 1'b1;
    end
    case (state_r)
      rau_pkg::S_IDLE: if (in_valid) state_nxt = rau_pkg::S_DISP;
      rau_pkg::S_DISP: begin
        red_nxt = 1'b0;
        if (stat.mode_mul) begin
          state_nxt = rau_pkg::S_MULN;
        end else if (stat.mode_cmp) begin
          state_nxt = rau_pkg::S_NEGY;
        end else begin
          state_nxt = rau_pkg::S_GSET;
        end
      end
      rau_pkg::S_OUT: if (out_free) state_nxt = rau_pkg::S_IDLE;
      default: begin
        if (issued_r && stat.done) begin
          issued_nxt = 1'b0;
          case (state_r)
            rau_pkg::S_MULN: state_nxt = rau_pkg::S_MULD;
            rau_pkg::S_MULD: begin
              red_nxt   = 1'b1;
              state_nxt = rau_pkg::S_GSET;
            end
            rau_pkg::S_NEGY: state_nxt = rau_pkg::S_GSET;
            rau_pkg::S_GSET, rau_pkg::S_GREM: begin
              if (stat.ka_zero || stat.keq) begin
                state_nxt = rau_pkg::S_GFIN;
              end else begin
                state_nxt = rau_pkg::S_GREM;
              end
            end
            rau_pkg::S_GFIN: begin
              if (stat.g_zero) begin
                state_nxt = rau_pkg::S_OUT;
              end else if (red_r) begin
                state_nxt = rau_pkg::S_DRN;
              end else begin
                state_nxt = rau_pkg::S_DMX;
              end
            end
            rau_pkg::S_DMX:  state_nxt = rau_pkg::S_DMY;
            rau_pkg::S_DMY:  state_nxt = rau_pkg::S_MXN;
            rau_pkg::S_MXN:  state_nxt = rau_pkg::S_MYN;
            rau_pkg::S_MYN:  state_nxt = rau_pkg::S_ADDN;
            rau_pkg::S_ADDN: state_nxt = rau_pkg::S_MXD;
            rau_pkg::S_MXD: begin
              red_nxt   = 1'b1;
              state_nxt = rau_pkg::S_GSET;
            end
            rau_pkg::S_DRN:  state_nxt = rau_pkg::S_DRD;
            rau_pkg::S_DRD:  state_nxt = rau_pkg::S_OUT;
            default:         state_nxt = rau_pkg::S_IDLE;
          endcase
        end
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd.load     = (state_r == rau_pkg::S_IDLE) && in_valid;
    cmd.go       = 1'b0;
    cmd.op       = rau_pkg::OP_NONE;
    cmd.a_sel    = rau_pkg::R_XN;
    cmd.b_sel    = rau_pkg::R_XN;
    cmd.dst_sel  = rau_pkg::R_T;
    cmd.out_load = (state_r == rau_pkg::S_OUT) && out_free;
    case (state_r)
      rau_pkg::S_MULN: begin
        cmd.op = rau_pkg::OP_MUL;
        cmd.a_sel = rau_pkg::R_XN; cmd.b_sel = rau_pkg::R_YN; cmd.dst_sel = rau_pkg::R_SN;
      end
      rau_pkg::S_MULD: begin
        cmd.op = rau_pkg::OP_MUL;
        cmd.a_sel = rau_pkg::R_XD; cmd.b_sel = rau_pkg::R_YD; cmd.dst_sel = rau_pkg::R_SD;
      end
      rau_pkg::S_NEGY: begin
        cmd.op = rau_pkg::OP_NEG;
        cmd.a_sel = rau_pkg::R_YN; cmd.dst_sel = rau_pkg::R_YN;
      end
      rau_pkg::S_GSET: begin
        cmd.op    = rau_pkg::OP_GSET;
        cmd.a_sel = red_r ? rau_pkg::R_SN : rau_pkg::R_XD;
        cmd.b_sel = red_r ? rau_pkg::R_SD : rau_pkg::R_YD;
      end
      rau_pkg::S_GREM: cmd.op = rau_pkg::OP_GREM;
      rau_pkg::S_GFIN: begin
        cmd.op = rau_pkg::OP_GFIN;
        cmd.dst_sel = rau_pkg::R_G;
      end
      rau_pkg::S_DMX: begin
        cmd.op = rau_pkg::OP_DIV;
        cmd.a_sel = rau_pkg::R_YD; cmd.b_sel = rau_pkg::R_G; cmd.dst_sel = rau_pkg::R_MX;
      end
      rau_pkg::S_DMY: begin
        cmd.op = rau_pkg::OP_DIV;
        cmd.a_sel = rau_pkg::R_XD; cmd.b_sel = rau_pkg::R_G; cmd.dst_sel = rau_pkg::R_MY;
      end
      rau_pkg::S_MXN: begin
        cmd.op = rau_pkg::OP_MUL;
        cmd.a_sel = rau_pkg::R_MX; cmd.b_sel = rau_pkg::R_XN; cmd.dst_sel = rau_pkg::R_T;
      end
      rau_pkg::S_MYN: begin
        cmd.op = rau_pkg::OP_MUL;
        cmd.a_sel = rau_pkg::R_MY; cmd.b_sel = rau_pkg::R_YN; cmd.dst_sel = rau_pkg::R_SN;
      end
      rau_pkg::S_ADDN: begin
        cmd.op = rau_pkg::OP_ADD;
        cmd.a_sel = rau_pkg::R_T; cmd.b_sel = rau_pkg::R_SN; cmd.dst_sel = rau_pkg::R_SN;
      end
      rau_pkg::S_MXD: begin
        cmd.op = rau_pkg::OP_MUL;
        cmd.a_sel = rau_pkg::R_MX; cmd.b_sel = rau_pkg::R_XD; cmd.dst_sel = rau_pkg::R_SD;
      end
      rau_pkg::S_DRN: begin
        cmd.op = rau_pkg::OP_DIV;
        cmd.a_sel = rau_pkg::R_SN; cmd.b_sel = rau_pkg::R_G; cmd.dst_sel = rau_pkg::R_RN;
      end
      rau_pkg::S_DRD: begin
        cmd.op = rau_pkg::OP_DIV;
        cmd.a_sel = rau_pkg::R_SD; cmd.b_sel = rau_pkg::R_G; cmd.dst_sel = rau_pkg::R_RD;
      end
      default: cmd.op = rau_pkg::OP_NONE;
    endcase
    if (cmd.op != rau_pkg::OP_NONE) begin
      cmd.go = !issued_r;
    end
  end

  // Output valid: set when the word is loaded, cleared when it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::S_IDLE;
      red_r       <= 1'b0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      red_r       <= red_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != rau_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ sv/rational_arith_unit_top.sv @@
// Channel | Ports                          | Word type
// input   | in_valid, in_stall, in_data    | rau_pkg::in_word_t
// output  | out_valid, out_stall, out_data | rau_pkg::out_word_t
//
// One word at a time. Multiply, divide and each Euclid remainder step run on one
// shared bit-serial unit. A word needs roughly 7 to 100 such multiplies, divides and
// remainder steps for add and compare, 4 to 50 for multiply; a zero over zero word
// stops early.
// Synchronous active-low reset clears control only.
// A finished word waits in the output register; the next input word is taken meanwhile.
module rational_arith_unit_top #(
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rau_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rau_pkg::out_word_t out_data
);

  rau_pkg::dp_cmd_t  cmd;
  rau_pkg::dp_stat_t stat;

  // Sequencer.
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Registers and arithmetic.
  rau_dp #(.W(WORD_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

@@ dv/rational_arith_checker.sv @@
module rational_arith_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rau_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rau_pkg::out_word_t out_data,
  output int                 n_errors,
  output int                 n_pending,
  output int                 n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MIN_VAL = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL = 32'h7FFF_FFFF;

  typedef logic [31:0] val_t;

  // Results still owed by the block, oldest first.
  rau_pkg::out_word_t owed_q[$];

  int err_cnt = 0;
  int pend_cnt = 0;
  int res_cnt = 0;

  assign n_errors  = err_cnt;
  assign n_pending = pend_cnt;
  assign n_results = res_cnt;

  function automatic val_t magnitude(val_t v);
    return v[31] ? -v : v;
  endfunction

  function automatic val_t neg_wrap(val_t v, inout bit ovf);
    if (v == MIN_VAL) ovf = 1'b1;
    return -v;
  endfunction

  function automatic val_t add_wrap(val_t a, val_t b, inout bit ovf);
    val_t r;
    r = a + b;
    if (a[31] == b[31] && r[31] != a[31]) ovf = 1'b1;
    return r;
  endfunction

  function automatic val_t mul_wrap(val_t a, val_t b, inout bit ovf);
    logic [63:0] ma, mb, lim;
    ma = 64'(magnitude(a));
    mb = 64'(magnitude(b));
    lim = (a[31] != b[31]) ? 64'(MIN_VAL) : 64'(MAX_VAL);
    if (ma != 0 && mb > lim / ma) ovf = 1'b1;
    return a * b;
  endfunction

  // Truncating division; the divisor is never zero here.
  function automatic val_t div_wrap(val_t a, val_t d, inout bit ovf);
    val_t q;
    bit neg;
    q = magnitude(a) / magnitude(d);
    neg = a[31] != d[31];
    if (!neg && q > MAX_VAL) ovf = 1'b1;
    return neg ? -q : q;
  endfunction

  // Euclid gcd carrying the sign of b, negative when b is zero.
  function automatic val_t signed_gcd(val_t a, val_t b);
    val_t ka, kb, t;
    ka = magnitude(a);
    kb = magnitude(b);
    if (ka == kb) return b;
    if (ka > kb) begin
      t = ka; ka = kb; kb = t;
    end
    while (ka != 0) begin
      t = ka;
      ka = kb % ka;
      kb = t;
    end
    if (!b[31] && b != 0) return kb;
    return -kb;
  endfunction

  function automatic rau_pkg::out_word_t predict_fraction(rau_pkg::in_word_t w);
    rau_pkg::out_word_t r;
    bit ovf, zr;
    val_t yn, g, mx, my, sn, sd, pn, pd, n, d;
    ovf = 1'b0;
    zr = 1'b0;
    n = '0;
    d = '0;
    yn = w.y_num;
    if (w.mode == rau_pkg::MODE_MUL) begin
      pn = mul_wrap(w.x_num, w.y_num, ovf);
      pd = mul_wrap(w.x_den, w.y_den, ovf);
      n = pn;
      d = pd;
    end else begin
      // Compare and the unused code both subtract y.
      if (w.mode >= rau_pkg::MODE_CMP) yn = neg_wrap(yn, ovf);
      g = signed_gcd(w.x_den, w.y_den);
      if (g == 0) begin
        zr = 1'b1;
      end else begin
        mx = div_wrap(w.y_den, g, ovf);
        my = div_wrap(w.x_den, g, ovf);
        sn = add_wrap(mul_wrap(mx, w.x_num, ovf), mul_wrap(my, yn, ovf), ovf);
        sd = mul_wrap(mx, w.x_den, ovf);
        n = sn;
        d = sd;
      end
    end
    // Final reduction by the gcd of the result.
    if (!zr) begin
      g = signed_gcd(n, d);
      if (g == 0) begin
        zr = 1'b1;
      end else begin
        n = div_wrap(n, g, ovf);
        d = div_wrap(d, g, ovf);
      end
    end
    r.res_num = zr ? '0 : n;
    r.res_den = zr ? '0 : d;
    r.status = zr ? rau_pkg::ST_ZERO : (ovf ? rau_pkg::ST_OVF : rau_pkg::ST_OK);
    return r;
  endfunction

  // Predict on every accepted input word, compare on every accepted result word.
  always @(posedge clk) begin
    rau_pkg::out_word_t exp_w;
    int errs;
    errs = 0;
    if (rst_n) begin
      if (in_valid && !in_stall) owed_q.push_back(predict_fraction(in_data));
      if (out_valid && !out_stall) begin
        res_cnt <= res_cnt + 1;
        if (owed_q.size() == 0) begin
          $error("result word with nothing expected: num=%0d den=%0d status=%0d",
                 out_data.res_num, out_data.res_den, out_data.status);
          errs++;
        end else begin
          exp_w = owed_q.pop_front();
          if (out_data.res_num !== exp_w.res_num) begin
            $error("res_num: expected %0d, got %0d", exp_w.res_num, out_data.res_num);
            errs++;
          end
          if (out_data.res_den !== exp_w.res_den) begin
            $error("res_den: expected %0d, got %0d", exp_w.res_den, out_data.res_den);
            errs++;
          end
          if (out_data.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, out_data.status);
            errs++;
          end
        end
      end
      err_cnt <= err_cnt + errs;
      pend_cnt <= owed_q.size();
    end
  end

endmodule

@@ dv/tb_rational_arith_unit_top.sv @@
module tb_rational_arith_unit_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] MIN_VAL = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL = 32'h7FFF_FFFF;
  localparam int N_RANDOM = 1500;
  localparam int DRAIN_CYCLES = 4000;
  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rau_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rau_pkg::out_word_t out_data;

  int n_errors, n_pending, n_results;
  int mode_count[4];
  int burst_left = 0;
  bit hold_request = 1'b0;
  longint cycle_count = 0;

  always #5 clk = ~clk;

  rational_arith_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rational_arith_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .n_errors(n_errors), .n_pending(n_pending), .n_results(n_results)
  );

  // Offer one word, with an occasional gap between bursts; returns once accepted.
  task automatic send_word(rau_pkg::in_word_t w);
    bit stalled;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    burst_left--;
    in_data <= w;
    in_valid <= 1'b1;
    mode_count[w.mode]++;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  function automatic logic [31:0] pick_value(bit is_den);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return 32'd1;
          2: return 32'hFFFF_FFFF;
          3: return MIN_VAL;
          default: return MAX_VAL;
        endcase
      end
      1, 2: return $urandom();
      3, 4: return 32'($signed($urandom_range(0, 65535)) - 32768);
      default: begin
        if (is_den) return $urandom_range(1, 60);
        return 32'($signed($urandom_range(0, 200)) - 100);
      end
    endcase
  endfunction

  function automatic rau_pkg::in_word_t make_word(logic [1:0] m, int xn, int xd, int yn,
                                                  int yd);
    rau_pkg::in_word_t w;
    w.mode = m;
    w.x_num = xn;
    w.x_den = xd;
    w.y_num = yn;
    w.y_den = yd;
    return w;
  endfunction

  // Receiver: stall density changes per window, plus one long hold-off on request.
  initial begin
    int density;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (12000) @(posedge clk);
      end
      density = $urandom_range(0, 3) * 30;
      repeat ($urandom_range(16, 200)) begin
        out_stall <= ($urandom_range(1, 100) <= density);
        @(posedge clk);
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rau_pkg::in_word_t w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: each operation, extremes and the special cases.
    send_word(make_word(rau_pkg::MODE_ADD, 1, 2, 1, 3));
    send_word(make_word(rau_pkg::MODE_MUL, 2, 3, 9, 4));
    send_word(make_word(rau_pkg::MODE_CMP, 1, 3, 1, 2));
    send_word(make_word(rau_pkg::MODE_RSV, 7, 5, 3, 5));
    send_word(make_word(rau_pkg::MODE_CMP, 4, 6, 2, 3));
    send_word(make_word(rau_pkg::MODE_ADD, 3, -4, 1, 6));
    send_word(make_word(rau_pkg::MODE_ADD, 5, 0, 3, 0));
    send_word(make_word(rau_pkg::MODE_MUL, -5, 0, 2, 1));
    send_word(make_word(rau_pkg::MODE_ADD, 0, 0, 0, 0));
    send_word(make_word(rau_pkg::MODE_ADD, 1, 0, 1, 0));
    send_word(make_word(rau_pkg::MODE_MUL, 0, 0, 4, 1));
    send_word(make_word(rau_pkg::MODE_MUL, 0, 5, 0, 7));
    send_word(make_word(rau_pkg::MODE_MUL, MAX_VAL, 1, MAX_VAL, 1));
    send_word(make_word(rau_pkg::MODE_MUL, MIN_VAL, 1, -1, 1));
    send_word(make_word(rau_pkg::MODE_CMP, 0, 1, MIN_VAL, 1));
    send_word(make_word(rau_pkg::MODE_ADD, MAX_VAL, 1, 1, 1));
    send_word(make_word(rau_pkg::MODE_ADD, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL));
    send_word(make_word(rau_pkg::MODE_ADD, 1, MAX_VAL, 1, MAX_VAL - 1));
    send_word(make_word(rau_pkg::MODE_CMP, -1, -1, -1, -1));
    send_word(make_word(rau_pkg::MODE_MUL, MIN_VAL, MIN_VAL, MAX_VAL, MAX_VAL));
    send_word(make_word(rau_pkg::MODE_ADD, -1, MIN_VAL, 1, 1));
    send_word(make_word(rau_pkg::MODE_RSV, MAX_VAL, -1, MIN_VAL, -1));

    // Random words, mostly well-formed fractions with small denominators.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_request = 1'b1;
      w.mode = ($urandom_range(0, 19) == 0) ? rau_pkg::MODE_RSV : 2'($urandom_range(0, 2));
      w.x_num = pick_value(1'b0);
      w.x_den = pick_value(1'b1);
      w.y_num = pick_value(1'b0);
      w.y_den = pick_value(1'b1);
      send_word(w);
    end
    in_valid <= 1'b0;

    // Drain what is still in flight.
    do @(negedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: add %0d, multiply %0d, compare %0d, unused mode %0d.",
             mode_count[rau_pkg::MODE_ADD] + mode_count[rau_pkg::MODE_MUL] +
             mode_count[rau_pkg::MODE_CMP] + mode_count[rau_pkg::MODE_RSV],
             mode_count[rau_pkg::MODE_ADD], mode_count[rau_pkg::MODE_MUL],
             mode_count[rau_pkg::MODE_CMP], mode_count[rau_pkg::MODE_RSV]);
    $display("Checked %0d result words over %0d cycles with random stalls and a long hold-off.",
             n_results, cycle_count);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
